>>> sv/tdr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tdr_pkg;

    // Payload size of a full block; a shorter in-order block ends the transfer.
    localparam logic [15:0] BLOCK_BYTES = 16'd512;

    // Retry limit after reset.
    localparam logic [7:0] MAX_RETRIES_RESET = 8'd5;

    // Expected block number after reset.
    localparam logic [15:0] FIRST_BLOCK = 16'd1;

    // Default depth of the action queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // TFTP opcodes that the receiver understands.
    localparam logic [15:0] OPC_DATA  = 16'd3;
    localparam logic [15:0] OPC_ERROR = 16'd5;

    // Input command codes.
    localparam logic CMD_PACKET  = 1'b0;
    localparam logic CMD_TIMEOUT = 1'b1;

    // Transfer phase.
    typedef enum logic [1:0] {
        PH_RUNNING  = 2'd0,
        PH_FINISHED = 2'd1,
        PH_ABORTED  = 2'd2
    } phase_t;

    // Packet to send.
    typedef enum logic [1:0] {
        SEND_NONE  = 2'd0,
        SEND_ACK   = 2'd1,
        SEND_ERROR = 2'd2
    } send_kind_t;

    // Error code carried by an ERROR packet.
    typedef enum logic {
        ERR_NOT_DEFINED = 1'b0,
        ERR_ILLEGAL_OP  = 1'b1
    } err_kind_t;

    // Action decided by the front for one input.
    typedef enum logic [1:0] {
        ACT_ACK     = 2'd0,   // one ACK result
        ACT_ACK_ERR = 2'd1,   // ACK, then ERROR that aborts
        ACT_ERR     = 2'd2,   // one ERROR result that aborts
        ACT_ABORT   = 2'd3    // silent abort, nothing sent
    } act_t;

    // One queued action.
    typedef struct packed {
        act_t        act;
        logic [15:0] ack_block;
        logic        store;
        logic        fin;
        err_kind_t   ekind;
    } action_t;

    // Increment that holds at the top of the 8-bit range.
    function automatic logic [7:0] sat_inc8(input logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

endpackage

`default_nettype wire

>>> sv/tdr_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tdr_front (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [7:0]         cfg_wr_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               cmd,
    input  wire logic [15:0]        opcode,
    input  wire logic [15:0]        block_number,
    input  wire logic [9:0]         payload_len,
    input  wire logic               q_full,
    output logic                    push_valid,
    output tdr_pkg::action_t        push_entry
);

    logic [7:0]       max_retries_reg;
    logic [15:0]      expected_reg, expected_next;
    logic [7:0]       timeout_reg, timeout_next;
    logic [7:0]       reorder_reg, reorder_next;
    tdr_pkg::phase_t  phase_reg, phase_next;

    logic [7:0]       timeout_inc;
    logic [7:0]       reorder_inc;
    logic             accept;

    assign in_ready    = !q_full;
    assign accept      = in_valid && !q_full;
    assign timeout_inc = tdr_pkg::sat_inc8(timeout_reg);
    assign reorder_inc = tdr_pkg::sat_inc8(reorder_reg);

    // Classify the input and update the transfer state.
    always_comb begin
        expected_next        = expected_reg;
        timeout_next         = timeout_reg;
        reorder_next         = reorder_reg;
        phase_next           = phase_reg;
        push_valid           = 1'b0;
        push_entry.act       = tdr_pkg::ACT_ACK;
        push_entry.ack_block = block_number;
        push_entry.store     = 1'b0;
        push_entry.fin       = 1'b0;
        push_entry.ekind     = tdr_pkg::ERR_NOT_DEFINED;

        if (accept && phase_reg == tdr_pkg::PH_RUNNING) begin
            if (cmd == tdr_pkg::CMD_TIMEOUT) begin
                timeout_next = timeout_inc;
                if (timeout_inc >= max_retries_reg) begin
                    phase_next       = tdr_pkg::PH_ABORTED;
                    push_valid       = 1'b1;
                    push_entry.act   = tdr_pkg::ACT_ERR;
                end
            end else begin
                timeout_next = '0;
                if (opcode == tdr_pkg::OPC_DATA) begin
                    push_valid = 1'b1;
                    if (block_number < expected_reg) begin
                        // Old duplicate: acknowledge it again.
                        reorder_next = '0;
                    end else if (block_number == expected_reg) begin
                        // In-order block: store, acknowledge and advance.
                        reorder_next     = '0;
                        expected_next    = expected_reg + 16'd1;
                        push_entry.store = 1'b1;
                        if ({6'd0, payload_len} < tdr_pkg::BLOCK_BYTES) begin
                            push_entry.fin = 1'b1;
                            phase_next     = tdr_pkg::PH_FINISHED;
                        end
                    end else begin
                        // Block ahead: acknowledge the last good one and count.
                        reorder_next         = reorder_inc;
                        push_entry.ack_block = expected_reg - 16'd1;
                        if (reorder_inc >= max_retries_reg) begin
                            push_entry.act = tdr_pkg::ACT_ACK_ERR;
                            phase_next     = tdr_pkg::PH_ABORTED;
                        end
                    end
                end else if (opcode == tdr_pkg::OPC_ERROR) begin
                    push_valid     = 1'b1;
                    push_entry.act = tdr_pkg::ACT_ABORT;
                    phase_next     = tdr_pkg::PH_ABORTED;
                end else begin
                    push_valid       = 1'b1;
                    push_entry.act   = tdr_pkg::ACT_ERR;
                    push_entry.ekind = tdr_pkg::ERR_ILLEGAL_OP;
                    phase_next       = tdr_pkg::PH_ABORTED;
                end
            end
        end
    end

    // State registers and the retry limit.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_retries_reg <= tdr_pkg::MAX_RETRIES_RESET;
            expected_reg    <= tdr_pkg::FIRST_BLOCK;
            timeout_reg     <= '0;
            reorder_reg     <= '0;
            phase_reg       <= tdr_pkg::PH_RUNNING;
        end else begin
            if (cfg_wr_en) begin
                max_retries_reg <= cfg_wr_data;
            end
            expected_reg <= expected_next;
            timeout_reg  <= timeout_next;
            reorder_reg  <= reorder_next;
            phase_reg    <= phase_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/tdr_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module tdr_queue #(
    parameter int DEPTH = tdr_pkg::QUEUE_DEPTH
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push_valid,
    input  wire tdr_pkg::action_t   push_entry,
    output logic                    full,
    output logic                    head_valid,
    output tdr_pkg::action_t        head,
    input  wire logic               pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    tdr_pkg::action_t entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

>>> sv/tdr_back.sv
`timescale 1ns / 1ps
`default_nettype none

module tdr_back (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               head_valid,
    input  wire tdr_pkg::action_t   head,
    output logic                    pop,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output tdr_pkg::send_kind_t     send_kind,
    output logic [15:0]             ack_block,
    output tdr_pkg::err_kind_t      error_kind,
    output logic                    store_payload,
    output logic                    finished,
    output logic                    aborted,
    output logic                    last
);

    logic                 valid_reg, valid_next;
    logic                 half_reg, half_next;
    tdr_pkg::send_kind_t  kind_reg, kind_next;
    logic [15:0]          ack_reg, ack_next;
    tdr_pkg::err_kind_t   ekind_reg, ekind_next;
    logic                 store_reg, store_next;
    logic                 fin_reg, fin_next;
    logic                 abort_reg, abort_next;
    logic                 last_reg, last_next;
    logic                 load;

    // The output register takes a new result when empty or being drained.
    assign load = !valid_reg || out_ready;

    // Expand the head action into one or two results.
    always_comb begin
        pop        = 1'b0;
        half_next  = half_reg;
        valid_next = load ? head_valid : valid_reg;
        kind_next  = tdr_pkg::SEND_ACK;
        ack_next   = head.ack_block;
        ekind_next = tdr_pkg::ERR_NOT_DEFINED;
        store_next = head.store;
        fin_next   = head.fin;
        abort_next = 1'b0;
        last_next  = 1'b1;

        if (load && head_valid) begin
            case (head.act)
                tdr_pkg::ACT_ACK: begin
                    pop = 1'b1;
                end
                tdr_pkg::ACT_ACK_ERR: begin
                    if (!half_reg) begin
                        last_next = 1'b0;
                        half_next = 1'b1;
                    end else begin
                        kind_next  = tdr_pkg::SEND_ERROR;
                        ack_next   = '0;
                        store_next = 1'b0;
                        fin_next   = 1'b0;
                        abort_next = 1'b1;
                        half_next  = 1'b0;
                        pop        = 1'b1;
                    end
                end
                tdr_pkg::ACT_ERR: begin
                    kind_next  = tdr_pkg::SEND_ERROR;
                    ack_next   = '0;
                    ekind_next = head.ekind;
                    store_next = 1'b0;
                    fin_next   = 1'b0;
                    abort_next = 1'b1;
                    pop        = 1'b1;
                end
                tdr_pkg::ACT_ABORT: begin
                    kind_next  = tdr_pkg::SEND_NONE;
                    ack_next   = '0;
                    store_next = 1'b0;
                    fin_next   = 1'b0;
                    abort_next = 1'b1;
                    pop        = 1'b1;
                end
                default: begin
                    pop = 1'b1;
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            half_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            half_reg  <= half_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge aclk) begin
        if (load && head_valid) begin
            kind_reg  <= kind_next;
            ack_reg   <= ack_next;
            ekind_reg <= ekind_next;
            store_reg <= store_next;
            fin_reg   <= fin_next;
            abort_reg <= abort_next;
            last_reg  <= last_next;
        end
    end

    assign out_valid     = valid_reg;
    assign send_kind     = kind_reg;
    assign ack_block     = ack_reg;
    assign error_kind    = ekind_reg;
    assign store_payload = store_reg;
    assign finished      = fin_reg;
    assign aborted       = abort_reg;
    assign last          = last_reg;

endmodule

`default_nettype wire

>>> sv/tftp_data_receiver_core.sv
// TFTP data receiver with lockstep acknowledgement, packet-header level.
// Input stream (s_*): one transfer per received packet header or timeout
// event. s_tuser carries the command (0 packet, 1 timeout); s_tdata carries
// the opcode, block number and saturated payload length.
// Output stream (m_*): the packets to send. m_tuser carries the send kind and
// error code; m_tdata the ACK block number and the store, finished and
// aborted flags; m_tlast marks the final result of one input.
// The retry limit is written through cfg_wr_en / cfg_wr_data; the user must
// write it only while idle, as the block itself does not enforce this. An
// accepted input's action is registered in the queue, and its result then in
// the back's output register. Throughput: one input per cycle while the queue
// is not full; an out-of-order block that hits the retry limit yields two
// results. The front decides and updates state in the accept cycle, a queue
// of QUEUE_DEPTH actions feeds the back, which drives the output register.
// When the receiver stalls, results collect in the queue; s_tready drops
// only once the queue is full. After reset the expected block is 1, all
// counts are zero, the limit is 5 and the queue is empty. Once the transfer
// finishes or aborts, further inputs are accepted and ignored until reset.
`timescale 1ns / 1ps
`default_nettype none

module tftp_data_receiver_core #(
    parameter int QUEUE_DEPTH = tdr_pkg::QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [15:0] opcode, [31:16] block_number, [41:32] payload_len, [47:42] zero
    input  wire logic [47:0] s_tdata,
    // [0] cmd
    input  wire logic [0:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [15:0] ack_block, [16] store_payload, [17] finished, [18] aborted,
    // [23:19] zero
    output logic [23:0]      m_tdata,
    // [1:0] send_kind, [2] error_kind
    output logic [2:0]       m_tuser,
    output logic             m_tlast
);

    logic                 q_full;
    logic                 push_valid;
    tdr_pkg::action_t     push_entry;
    logic                 head_valid;
    tdr_pkg::action_t     head;
    logic                 pop;
    tdr_pkg::send_kind_t  send_kind;
    logic [15:0]          ack_block;
    tdr_pkg::err_kind_t   error_kind;
    logic                 store_payload;
    logic                 finished;
    logic                 aborted;

    // Classification and transfer state.
    tdr_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .cmd          (s_tuser[0]),
        .opcode       (s_tdata[15:0]),
        .block_number (s_tdata[31:16]),
        .payload_len  (s_tdata[41:32]),
        .q_full       (q_full),
        .push_valid   (push_valid),
        .push_entry   (push_entry)
    );

    // Action queue.
    tdr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    // Result generation and output register.
    tdr_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (head_valid),
        .head          (head),
        .pop           (pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .send_kind     (send_kind),
        .ack_block     (ack_block),
        .error_kind    (error_kind),
        .store_payload (store_payload),
        .finished      (finished),
        .aborted       (aborted),
        .last          (m_tlast)
    );

    assign m_tdata = {5'd0, aborted, finished, store_payload, ack_block};
    assign m_tuser = {error_kind, send_kind};

`ifndef SYNTHESIS
    // An ERROR result always ends the input and the transfer.
    a_error_aborts: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (send_kind == tdr_pkg::SEND_ERROR) |-> aborted && m_tlast)
        else $error("ERROR result without abort or last");

    // Only an ACK result marks its payload for storing.
    a_store_is_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && store_payload |-> send_kind == tdr_pkg::SEND_ACK)
        else $error("store flag on a non-ACK result");

    // Once an action ends the transfer, the front queues nothing more.
    a_no_push_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid && (push_entry.fin || push_entry.act != tdr_pkg::ACT_ACK)
        |=> !push_valid)
        else $error("action queued after the transfer ended");
`endif

endmodule

`default_nettype wire

>>> tb/tftp_data_receiver_core_tb.sv
`timescale 1ns / 1ps

module tftp_data_receiver_core_tb;

    // One reply that the receiver is expected to send.
    typedef struct {
        tdr_pkg::send_kind_t kind;
        logic [15:0]         ack_block;
        tdr_pkg::err_kind_t  err;
        logic                store;
        logic                done;
        logic                abort;
        logic                tail;
    } rx_reply_t;

    // How the single transfer of the run is brought to its end.
    typedef enum int {
        END_SHORT_BLOCK,
        END_PEER_ERROR,
        END_ILLEGAL_OP,
        END_TIMEOUTS,
        END_REORDER
    } ending_t;

    // Quiet cycles (no transfer on either side) before the run is abandoned.
    localparam int IDLE_LIMIT = 200;

    // Tracks the receiver state and the replies still owed by the block.
    class tftp_rx_scoreboard;
        logic [7:0]       retry_limit;
        logic [15:0]      next_block;
        logic [7:0]       timeouts_seen;
        logic [7:0]       reorders_seen;
        tdr_pkg::phase_t  xfer_phase;
        rx_reply_t        replies_due[$];
        int               mismatches;

        function new();
            retry_limit   = 8'd5;
            next_block    = 16'd1;
            timeouts_seen = 8'd0;
            reorders_seen = 8'd0;
            xfer_phase    = tdr_pkg::PH_RUNNING;
            mismatches    = 0;
        endfunction

        function void owe(tdr_pkg::send_kind_t kind, logic [15:0] ack_block,
                          tdr_pkg::err_kind_t err, logic store, logic done,
                          logic abort, logic tail);
            rx_reply_t r;
            r.kind      = kind;
            r.ack_block = ack_block;
            r.err       = err;
            r.store     = store;
            r.done      = done;
            r.abort     = abort;
            r.tail      = tail;
            replies_due.push_back(r);
        endfunction

        // Works out the replies to one accepted input transfer.
        function void note_rx_event(logic cmd, logic [15:0] opcode, logic [15:0] blk,
                                    logic [9:0] plen);
            logic [15:0] prev_block;
            logic        short_block;
            if (xfer_phase != tdr_pkg::PH_RUNNING)
                return;

            // A timeout only answers once the limit is reached.
            if (cmd == tdr_pkg::CMD_TIMEOUT) begin
                timeouts_seen = (timeouts_seen == 8'hFF) ? timeouts_seen
                                                         : timeouts_seen + 8'd1;
                if (timeouts_seen >= retry_limit) begin
                    xfer_phase = tdr_pkg::PH_ABORTED;
                    owe(tdr_pkg::SEND_ERROR, 16'd0, tdr_pkg::ERR_NOT_DEFINED,
                        1'b0, 1'b0, 1'b1, 1'b1);
                end
                return;
            end

            timeouts_seen = 8'd0;
            if (opcode == tdr_pkg::OPC_DATA) begin
                if (blk < next_block) begin
                    // Old duplicate: re-acknowledge it with its own number.
                    reorders_seen = 8'd0;
                    owe(tdr_pkg::SEND_ACK, blk, tdr_pkg::ERR_NOT_DEFINED,
                        1'b0, 1'b0, 1'b0, 1'b1);
                end else if (blk == next_block) begin
                    short_block   = (16'(plen) < tdr_pkg::BLOCK_BYTES);
                    reorders_seen = 8'd0;
                    next_block    = next_block + 16'd1;
                    if (short_block)
                        xfer_phase = tdr_pkg::PH_FINISHED;
                    owe(tdr_pkg::SEND_ACK, blk, tdr_pkg::ERR_NOT_DEFINED,
                        1'b1, short_block, 1'b0, 1'b1);
                end else begin
                    // Block ahead of the expected one.
                    reorders_seen = (reorders_seen == 8'hFF) ? reorders_seen
                                                             : reorders_seen + 8'd1;
                    prev_block = next_block - 16'd1;
                    if (reorders_seen < retry_limit) begin
                        owe(tdr_pkg::SEND_ACK, prev_block, tdr_pkg::ERR_NOT_DEFINED,
                            1'b0, 1'b0, 1'b0, 1'b1);
                    end else begin
                        xfer_phase = tdr_pkg::PH_ABORTED;
                        owe(tdr_pkg::SEND_ACK, prev_block, tdr_pkg::ERR_NOT_DEFINED,
                            1'b0, 1'b0, 1'b0, 1'b0);
                        owe(tdr_pkg::SEND_ERROR, 16'd0, tdr_pkg::ERR_NOT_DEFINED,
                            1'b0, 1'b0, 1'b1, 1'b1);
                    end
                end
            end else if (opcode == tdr_pkg::OPC_ERROR) begin
                xfer_phase = tdr_pkg::PH_ABORTED;
                owe(tdr_pkg::SEND_NONE, 16'd0, tdr_pkg::ERR_NOT_DEFINED,
                    1'b0, 1'b0, 1'b1, 1'b1);
            end else begin
                xfer_phase = tdr_pkg::PH_ABORTED;
                owe(tdr_pkg::SEND_ERROR, 16'd0, tdr_pkg::ERR_ILLEGAL_OP,
                    1'b0, 1'b0, 1'b1, 1'b1);
            end
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        // Compares one output transfer with the oldest reply owed.
        function void check_reply(logic [2:0] tuser, logic [23:0] tdata, logic tlast);
            rx_reply_t want;
            if (replies_due.size() == 0) begin
                $error("reply with nothing pending: send_kind %0d, ack_block %0d",
                       tuser[1:0], tdata[15:0]);
                mismatches++;
                return;
            end
            want = replies_due.pop_front();
            compare_field("send_kind", 16'(want.kind), 16'(tuser[1:0]));
            compare_field("ack_block", want.ack_block, tdata[15:0]);
            compare_field("error_kind", 16'(want.err), 16'(tuser[2]));
            compare_field("store_payload", 16'(want.store), 16'(tdata[16]));
            compare_field("finished", 16'(want.done), 16'(tdata[17]));
            compare_field("aborted", 16'(want.abort), 16'(tdata[18]));
            compare_field("last", 16'(want.tail), 16'(tlast));
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [7:0]  cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    logic idle_on;

    tftp_rx_scoreboard sb = new();

    tftp_data_receiver_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Present one input item and hold it until the transfer completes.
    task automatic send_item(input logic cmd, input logic [15:0] opcode,
                             input logic [15:0] blk, input logic [9:0] plen);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {6'd0, plen, blk, opcode};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_rx_event(cmd, opcode, blk, plen);
    endtask

    task automatic send_data(input logic [15:0] blk, input logic [9:0] plen);
        send_item(tdr_pkg::CMD_PACKET, tdr_pkg::OPC_DATA, blk, plen);
    endtask

    // The packet fields of a timeout carry random junk.
    task automatic send_timeout();
        send_item(tdr_pkg::CMD_TIMEOUT, 16'($urandom), 16'($urandom),
                  10'($urandom_range(0, 512)));
    endtask

    // Data block beyond the expected one, either just past it or far ahead.
    task automatic send_ahead();
        int lo;
        int blk;
        lo = int'(sb.next_block) + 1;
        if ($urandom_range(0, 1) == 0)
            blk = lo + $urandom_range(0, 2);
        else
            blk = $urandom_range(lo, 65535);
        if (blk > 65535)
            blk = 65535;
        send_data(16'(blk), 10'($urandom_range(0, 512)));
    endtask

    // A well-formed item chosen so that the transfer keeps running.
    task automatic send_random_item();
        int roll;
        int exp_blk;
        roll    = $urandom_range(0, 99);
        exp_blk = int'(sb.next_block);
        if (roll < 40) begin
            send_data(sb.next_block, 10'd512);
        end else if (roll < 60 && exp_blk > 0) begin
            if ($urandom_range(0, 1) == 0)
                send_data(16'(exp_blk - 1), 10'($urandom_range(0, 512)));
            else
                send_data(16'($urandom_range(0, exp_blk - 1)), 10'($urandom_range(0, 512)));
        end else if (roll < 78 && exp_blk != 65535 && sb.reorders_seen + 1 < sb.retry_limit) begin
            send_ahead();
        end else if (sb.timeouts_seen + 1 < sb.retry_limit) begin
            send_timeout();
        end else begin
            send_data(sb.next_block, 10'd512);
        end
    endtask

    // Let every reply drain, then give the pipeline time to settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.replies_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [7:0] value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.retry_limit = value;
    endtask

    // Receiver side: accept with random stall bursts while idling is on.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // Check every reply transfer.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_reply(m_tuser, m_tdata, m_tlast);
    end

    // Abandon the run when nothing moves for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        ending_t     ending;
        logic [7:0]  limit_pick;
        logic [15:0] op;

        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 8'd0;
        s_tvalid    <= 1'b0;
        s_tdata     <= 48'd0;
        s_tuser     <= tdr_pkg::CMD_PACKET;
        idle_on = 1'b1;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part under the retry limit that reset leaves.
        send_data(16'd1, 10'd512);
        send_data(16'd0, 10'd0);
        send_data(16'd1, 10'd511);
        send_data(16'hFFFF, 10'd512);
        send_data(16'd3, 10'd100);
        send_data(16'd2, 10'd512);
        send_item(tdr_pkg::CMD_TIMEOUT, 16'hFFFF, 16'hFFFF, 10'd512);
        send_item(tdr_pkg::CMD_TIMEOUT, 16'd0, 16'd0, 10'd0);
        send_data(16'd1, 10'd256);
        repeat (4) send_timeout();
        send_data(16'd3, 10'd512);

        // Widest limit: long runs of reordered blocks and timeouts.
        write_limit(8'd255);
        repeat (6) send_ahead();
        repeat (6) send_timeout();
        send_data(16'd4, 10'd512);

        // Tightest limit: only in-order and duplicate blocks keep it alive.
        write_limit(8'd1);
        send_data(16'd5, 10'd512);
        send_data(16'd2, 10'd7);
        send_data(16'd6, 10'd512);

        // A short run of back-to-back in-order blocks.
        idle_on = 1'b0;
        repeat (20)
            send_data(sb.next_block, 10'd512);

        // Random phases under several limits.
        for (int p = 0; p < 5; p++) begin
            case (p)
                0:       limit_pick = 8'd2;
                1:       limit_pick = 8'd255;
                2:       limit_pick = 8'($urandom_range(3, 20));
                3:       limit_pick = 8'd1;
                default: limit_pick = 8'($urandom_range(1, 255));
            endcase
            idle_on = (p != 2) && (p != 4);
            write_limit(limit_pick);
            repeat (250) send_random_item();
        end

        // End the transfer in one of the ways the receiver knows.
        write_limit(8'($urandom_range(1, 4)));
        ending = ending_t'($urandom_range(0, 4));
        case (ending)
            END_SHORT_BLOCK: begin
                send_data(sb.next_block, 10'($urandom_range(0, 511)));
            end
            END_PEER_ERROR: begin
                send_item(tdr_pkg::CMD_PACKET, tdr_pkg::OPC_ERROR, 16'($urandom),
                          10'($urandom_range(0, 512)));
            end
            END_ILLEGAL_OP: begin
                op = 16'($urandom);
                if (op == tdr_pkg::OPC_DATA || op == tdr_pkg::OPC_ERROR)
                    op = 16'hFFFF;
                send_item(tdr_pkg::CMD_PACKET, op, 16'($urandom),
                          10'($urandom_range(0, 512)));
            end
            END_TIMEOUTS: begin
                while (sb.xfer_phase == tdr_pkg::PH_RUNNING)
                    send_timeout();
            end
            default: begin
                if (sb.next_block == 16'hFFFF)
                    send_data(16'hFFFF, 10'd512);
                while (sb.xfer_phase == tdr_pkg::PH_RUNNING)
                    send_ahead();
            end
        endcase

        // Inputs after the end must be taken and ignored.
        repeat (8)
            send_item(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                      10'($urandom_range(0, 512)));
        s_tvalid <= 1'b0;

        while (sb.replies_due.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (sb.mismatches == 0 && sb.replies_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
